// File: hdl/mpd_pkg.sv
`timescale 1ns / 1ps

package mpd_pkg;

  localparam int unsigned DATA_W           = 8;
  localparam int unsigned LEN_W            = 28;
  localparam int unsigned IDX_W            = 2;
  localparam int unsigned MAX_LENGTH_BYTES = 4;
  localparam int unsigned GROUP_W          = 7;
  localparam int unsigned STATUS_W         = 2;
  localparam int unsigned USER_W           = STATUS_W + 1;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = {LEN_W{1'b1}};

  typedef enum logic [1:0] {
    PH_TYPE    = 2'd0,
    PH_LEN     = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_HALT    = 2'd3
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_DISCARDED = 2'd3
  } status_e;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              pkt_start;
    logic              pkt_end;
    status_e           status;
  } result_t;

endpackage

// File: hdl/mqtt_packet_deframer.sv
`timescale 1ns / 1ps
// channel   | direction | beat contents
// s_axis    | in        | tdata[7:0] received stream byte
// m_axis    | out       | tdata[7:0] byte, tlast packet end, tuser[0] start, tuser[2:1] status
// cfg       | in        | cfg_wdata_i[27:0] max remaining length, written when cfg_we_i
//
// one beat per cycle in and out while m_axis keeps taking beats; each byte is parsed
// by the single parse stage on accept and registered in the output buffer.
// reset clears the parse state and the max length to all ones, no clearing pass.
// a two-entry output buffer keeps s_axis_tready registered; ready drops only
// while both entries hold beats that m_axis has not taken.

module mqtt_packet_deframer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mpd_pkg::LEN_W-1:0]  cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] data_in
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,   // [7:0] data_out
  output logic                       m_axis_tlast,   // packet_end
  output logic [mpd_pkg::USER_W-1:0] m_axis_tuser    // [0] packet_start, [2:1] status
);
  import mpd_pkg::*;

  logic    in_fire;
  result_t res;
  result_t out_res;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  mpd_frame_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (in_fire),
    .byte_i      (s_axis_tdata),
    .res_o       (res)
  );

  mpd_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = out_res.data;
  assign m_axis_tlast = out_res.pkt_end;
  assign m_axis_tuser = {out_res.status, out_res.pkt_start};

endmodule

// File: hdl/mpd_frame_fsm.sv
`timescale 1ns / 1ps

module mpd_frame_fsm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mpd_pkg::LEN_W-1:0]  cfg_wdata_i,
  input  logic                       fire_i,
  input  logic [mpd_pkg::DATA_W-1:0] byte_i,
  output mpd_pkg::result_t           res_o
);
  import mpd_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [LEN_W-1:0]       acc_q, acc_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [LEN_W-1:0]       left_q, left_d;
  logic [LEN_W-1:0]       max_q;

  logic [LEN_W-1:0]       group_ext;
  logic [LEN_W-1:0]       group_sh;
  logic [LEN_W-1:0]       acc_sum;
  logic [LEN_W-1:0]       left_dec;
  logic [IDX_W:0]         idx_inc;

  assign group_ext = LEN_W'(byte_i[GROUP_W-1:0]);
  assign acc_sum   = acc_q + group_sh;
  assign left_dec  = left_q - LEN_W'(1);
  assign idx_inc   = {1'b0, idx_q} + (IDX_W+1)'(1);

  // place the seven value bits at the group position of this length byte
  always_comb begin
    case (idx_q)
      2'd0:    group_sh = group_ext;
      2'd1:    group_sh = group_ext << GROUP_W;
      2'd2:    group_sh = group_ext << (2 * GROUP_W);
      2'd3:    group_sh = group_ext << (3 * GROUP_W);
      default: group_sh = group_ext;
    endcase
  end

  always_comb begin
    phase_d           = phase_q;
    acc_d             = acc_q;
    idx_d             = idx_q;
    left_d            = left_q;
    res_o.data        = byte_i;
    res_o.pkt_start   = 1'b0;
    res_o.pkt_end     = 1'b0;
    res_o.status      = ST_OK;
    case (phase_q)
      PH_TYPE: begin
        res_o.pkt_start = 1'b1;
        acc_d           = '0;
        idx_d           = '0;
        phase_d         = PH_LEN;
      end
      PH_LEN: begin
        acc_d = acc_sum;
        if (byte_i[DATA_W-1]) begin
          if (idx_inc >= (IDX_W+1)'(MAX_LENGTH_BYTES)) begin
            res_o.status = ST_MALFORMED;
            phase_d      = PH_HALT;
          end else begin
            idx_d = idx_inc[IDX_W-1:0];
          end
        end else if (acc_sum > max_q) begin
          res_o.status = ST_TOO_LARGE;
          phase_d      = PH_HALT;
        end else if (acc_sum == '0) begin
          res_o.pkt_end = 1'b1;
          phase_d       = PH_TYPE;
        end else begin
          left_d  = acc_sum;
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        left_d = left_dec;
        if (left_dec == '0) begin
          res_o.pkt_end = 1'b1;
          phase_d       = PH_TYPE;
        end
      end
      default: begin
        res_o.data   = '0;
        res_o.status = ST_DISCARDED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      acc_q   <= '0;
      idx_q   <= '0;
      left_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      idx_q   <= idx_d;
      left_q  <= left_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

endmodule

// File: hdl/mpd_skid.sv
`timescale 1ns / 1ps

module mpd_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mpd_pkg::result_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mpd_pkg::result_t out_data_o
);
  import mpd_pkg::*;

  logic    out_v_q, out_v_d;
  logic    skid_v_q, skid_v_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    in_fire;

  assign in_ready_o  = !skid_v_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        out_v_d  = 1'b1;
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end else begin
        out_v_d = in_fire;
        out_d   = in_data_i;
      end
    end else if (in_fire) begin
      // output stalled: park the new beat
      skid_v_d = 1'b1;
      skid_d   = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

// File: hdl/mpd_checker.sv
`timescale 1ns / 1ps

module mpd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [7:0]                 m_axis_tdata,
  input logic                       m_axis_tlast,
  input logic [mpd_pkg::USER_W-1:0] m_axis_tuser
);
  import mpd_pkg::*;

  // a type byte never carries an error
  a_start_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[2:1] == ST_OK)
    else $error("packet start beat with error status");

  // a packet only ends cleanly
  a_end_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[2:1] == ST_OK)
    else $error("packet end beat with error status");

  // discarded bytes are zeroed and unmarked
  a_discard_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2:1] == ST_DISCARDED
      |-> m_axis_tdata == 8'd0 && !m_axis_tlast && !m_axis_tuser[0])
    else $error("discarded beat carries data or marks");

  // once discarding starts, every later beat is discarded
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser[2:1] != ST_OK ##1 m_axis_tvalid
      |-> m_axis_tuser[2:1] == ST_DISCARDED)
    else $error("beat after an error not discarded");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready
      |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
          && $stable(m_axis_tlast))
    else $error("stalled output beat changed");

endmodule

bind mqtt_packet_deframer mpd_checker u_mpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

// File: tb/sv/tb_mqtt_packet_deframer.sv
`timescale 1ns / 1ps

module tb_mqtt_packet_deframer;
  import mpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_BYTES = 80;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [LEN_W-1:0]    cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic                m_axis_tlast;
  logic [USER_W-1:0]   m_axis_tuser;

  mqtt_packet_deframer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // stream bytes waiting to go out, and the framed beats they must produce
  logic [7:0]  wire_q[$];
  result_t     framed_q[$];
  result_t     want_beat;
  int unsigned bytes_queued   = 0;
  int unsigned beat_count     = 0;
  int unsigned err_count      = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          beat_up        = 1'b0;

  // deframer state as the block should hold it
  phase_e           mdl_phase = PH_TYPE;
  logic [LEN_W-1:0] mdl_acc   = '0;
  logic [IDX_W-1:0] mdl_idx   = '0;
  logic [LEN_W-1:0] mdl_left  = '0;
  logic [LEN_W-1:0] mdl_max   = MAX_LEN_RESET;

  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t r;
    r.data      = b;
    r.pkt_start = 1'b0;
    r.pkt_end   = 1'b0;
    r.status    = ST_OK;
    case (mdl_phase)
      PH_TYPE: begin
        r.pkt_start = 1'b1;
        mdl_acc     = '0;
        mdl_idx     = '0;
        mdl_phase   = PH_LEN;
      end
      PH_LEN: begin
        mdl_acc = mdl_acc + (LEN_W'(b[6:0]) << (GROUP_W * mdl_idx));
        if (b[7]) begin
          if (mdl_idx == IDX_W'(MAX_LENGTH_BYTES - 1)) begin
            r.status  = ST_MALFORMED;
            mdl_phase = PH_HALT;
          end else begin
            mdl_idx = mdl_idx + 1'b1;
          end
        end else if (mdl_acc > mdl_max) begin
          r.status  = ST_TOO_LARGE;
          mdl_phase = PH_HALT;
        end else if (mdl_acc == '0) begin
          r.pkt_end = 1'b1;
          mdl_phase = PH_TYPE;
        end else begin
          mdl_left  = mdl_acc;
          mdl_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        mdl_left = mdl_left - 1'b1;
        if (mdl_left == '0) begin
          r.pkt_end = 1'b1;
          mdl_phase = PH_TYPE;
        end
      end
      default: begin
        r.data   = '0;
        r.status = ST_DISCARDED;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch on %s at beat %0d: got %0h, want %0h", what, beat_count, got, want);
    err_count++;
  endtask

  function automatic int unsigned varint_bytes(input int unsigned len);
    int unsigned n;
    n = 1;
    while (n < MAX_LENGTH_BYTES && (len >> (GROUP_W * n)) != 0) n++;
    return n;
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    wire_q.push_back(b);
    bytes_queued++;
  endtask

  // type byte, n_len length bytes (padded with empty groups), then the body if body is set
  task automatic queue_packet(input logic [7:0] kind, input int unsigned len,
                              input int unsigned n_len, input bit body);
    logic [6:0] grp;
    queue_byte(kind);
    for (int i = 0; i < n_len; i++) begin
      grp = 7'(len >> (GROUP_W * i));
      queue_byte({(i + 1 < n_len), grp});
    end
    if (body) begin
      for (int i = 0; i < len; i++) queue_byte(8'($urandom));
    end
  endtask

  task automatic rand_packet(input int unsigned limit);
    int unsigned r;
    int unsigned len;
    int unsigned n;
    r = $urandom_range(99);
    if (r < 15) len = 0;
    else if (r < 80) len = $urandom_range(1, 20);
    else len = $urandom_range(21, 200);
    if (len > limit) len = $urandom_range(0, limit);
    n = varint_bytes(len);
    if ($urandom_range(3) == 0) n = $urandom_range(n, MAX_LENGTH_BYTES);
    queue_packet(8'($urandom), len, n, 1'b1);
  endtask

  task automatic wait_drained;
    while (wire_q.size() != 0 || framed_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [LEN_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    mdl_max = v;
  endtask

  task automatic set_idle_mode(input int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
      default: begin send_idle_pct = 25; recv_stall_pct = 25; end
    endcase
  endtask

  // accept side: predict each byte as it is taken
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      framed_q.push_back(deframe_byte(s_axis_tdata));
      void'(wire_q.pop_front());
      beat_up = 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && !beat_up) begin
      if (wire_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= wire_q[0];
        beat_up = 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'($urandom);
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (framed_q.size() == 0) begin
        report_mismatch("beat with nothing pending", m_axis_tdata, 0);
      end else begin
        want_beat = framed_q.pop_front();
        if (m_axis_tdata !== want_beat.data)
          report_mismatch("data", m_axis_tdata, want_beat.data);
        if (m_axis_tuser[0] !== want_beat.pkt_start)
          report_mismatch("packet start", m_axis_tuser[0], want_beat.pkt_start);
        if (m_axis_tlast !== want_beat.pkt_end)
          report_mismatch("packet end", m_axis_tlast, want_beat.pkt_end);
        if (m_axis_tuser[2:1] !== want_beat.status)
          report_mismatch("status", m_axis_tuser[2:1], want_beat.status);
      end
      beat_count++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mqtt_packet_deframer verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned p_max[5];
    int unsigned mark;
    int unsigned lim;
    int unsigned bad_len;
    bit          paused;

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero length, padded encodings, byte extremes, default max
    set_idle_mode(0);
    queue_byte(8'hFF); queue_byte(8'h00);
    queue_byte(8'h00); queue_byte(8'h81); queue_byte(8'h80); queue_byte(8'h80);
    queue_byte(8'h00); queue_byte(8'hFF);
    queue_byte(8'h30); queue_byte(8'h80); queue_byte(8'h80); queue_byte(8'h00);
    queue_byte(8'hA5); queue_byte(8'h82); queue_byte(8'h00); queue_byte(8'h5A);
    queue_byte(8'h00);
    wait_drained();

    p_max[0] = 0;
    p_max[1] = 1;
    p_max[2] = 37;
    p_max[3] = $urandom_range(2, 300);
    p_max[4] = MAX_LEN_RESET;
    for (int p = 0; p < 5; p++) begin
      set_idle_mode(p % 4);
      cfg_write(LEN_W'(p_max[p]));
      // a packet exactly at the limit
      if (p_max[p] <= 200) queue_packet(8'($urandom), p_max[p], varint_bytes(p_max[p]), 1'b1);
      mark   = bytes_queued;
      paused = 1'b0;
      while (bytes_queued - mark < PHASE_BYTES) begin
        rand_packet(p_max[p]);
        if (!paused && bytes_queued - mark >= PHASE_BYTES / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
      wait_drained();
    end

    // the halt can be hit only once per run
    set_idle_mode($urandom_range(3));
    if ($urandom_range(1) == 1) begin
      lim = $urandom_range(0, 300);
      cfg_write(LEN_W'(lim));
      repeat (3) rand_packet(lim);
      if ($urandom_range(1) == 1) bad_len = lim + 1;
      else bad_len = $urandom_range(lim + 1, MAX_LEN_RESET);
      queue_packet(8'($urandom), bad_len, varint_bytes(bad_len), 1'b0);
    end else begin
      rand_packet(MAX_LEN_RESET);
      queue_byte(8'($urandom));
      repeat (MAX_LENGTH_BYTES) queue_byte({1'b1, 7'($urandom)});
    end
    repeat (20) queue_byte(8'($urandom));
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (framed_q.size() != 0) report_mismatch("beats never delivered", framed_q.size(), 0);
    if (err_count == 0) begin
      $display("mqtt_packet_deframer verification clean");
    end else begin
      $display("mqtt_packet_deframer verification failed");
    end
    $finish;
  end

endmodule
